FILE: hdl/json_string_unescape_utf8_assert.svh
// Assertion macros used by the checker file.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication.
`define JSU_ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int CP_W       = 21;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 1'd1;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    // One entry of the queue between the front and back ends.
    typedef struct packed {
        logic            is_cp;
        logic [1:0]      st;
        logic [CP_W-1:0] cp;
        logic [2:0]      len;
    } t_evt;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Returns 16 for a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
        return v;
    endfunction

    function automatic logic [2:0] cp_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp <= 21'h7f) n = 3'd1;
        else if (cp <= 21'h7ff) n = 3'd2;
        else if (cp <= 21'hffff) n = 3'd3;
        else n = 3'd4;
        return n;
    endfunction

    // UTF-8 bytes of a code point, first byte in bits 7:0.
    function automatic logic [31:0] utf8_encode(input logic [CP_W-1:0] cp);
        logic [31:0] e;
        e = '0;
        if (cp <= 21'h7f) begin
            e[7:0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            e[7:0]  = {3'b110, cp[10:6]};
            e[15:8] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            e[7:0]   = {4'b1110, cp[15:12]};
            e[15:8]  = {2'b10, cp[11:6]};
            e[23:16] = {2'b10, cp[5:0]};
        end else begin
            e[7:0]   = {5'b11110, cp[20:18]};
            e[15:8]  = {2'b10, cp[17:12]};
            e[23:16] = {2'b10, cp[11:6]};
            e[31:24] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

FILE: hdl/jsu_front.sv
`timescale 1ns / 1ps
module jsu_front #(
    parameter int CAPACITY_MAX = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_req_type,
    input  logic [7:0]      i_in_byte,
    input  jsu_pkg::t_cfg_wr i_cfg,
    output jsu_pkg::t_evt   o_evt
);
    import jsu_pkg::*;

    localparam int CW   = $clog2(CAPACITY_MAX + 5);
    localparam int CMPW = ((CW > CFG_DATA_W) ? CW : CFG_DATA_W) + 1;
    localparam logic [CMPW-1:0] CAP_MAX = CMPW'(CAPACITY_MAX);
    localparam logic [CMPW-1:0] CNT_LIM = CMPW'(CAPACITY_MAX + 4);

    typedef enum logic [3:0] {
        S_IDLE, S_STR, S_ESC, S_HEX, S_PAIR_BS, S_PAIR_U, S_PAIR_HEX, S_UTF8
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [2:0]            r_hex_left, n_hex_left;
    logic [CP_W-1:0]       r_code_acc, n_code_acc;
    logic [9:0]            r_high_half, n_high_half;
    logic [1:0]            r_cont_left, n_cont_left;
    logic [1:0]            r_min_class, n_min_class;
    logic [CW-1:0]         r_out_count, n_out_count;
    logic [CFG_DATA_W-1:0] r_capacity;
    logic                  r_limit_en;

    logic            want_cp;
    logic [CP_W-1:0] cp_val;
    logic [1:0]      st;
    logic [4:0]      hex_d;
    logic [15:0]     hex_acc;
    logic [CP_W-1:0] utf_acc;
    logic [CP_W-1:0] min_val;
    logic [2:0]      len;
    logic [CMPW-1:0] cap_sat;
    logic [CMPW-1:0] sum;

    always_comb begin
        n_phase     = r_phase;
        n_hex_left  = r_hex_left;
        n_code_acc  = r_code_acc;
        n_high_half = r_high_half;
        n_cont_left = r_cont_left;
        n_min_class = r_min_class;
        n_out_count = r_out_count;
        want_cp     = 1'b0;
        cp_val      = '0;
        st          = ST_RUN;
        hex_d       = hex_value(i_in_byte);
        hex_acc     = {r_code_acc[11:0], hex_d[3:0]};
        utf_acc     = {r_code_acc[14:0], i_in_byte[5:0]};
        case (r_min_class)
            2'd1:    min_val = 21'h80;
            2'd2:    min_val = 21'h800;
            default: min_val = 21'h10000;
        endcase

        if (i_req_type) begin
            st = ST_BAD;
        end else begin
            case (r_phase)
                S_IDLE: begin
                    if (i_in_byte inside {8'h20, 8'h09, 8'h0d, 8'h0a}) begin
                        st = ST_RUN;
                    end else if (i_in_byte == 8'h22) begin
                        n_phase     = S_STR;
                        n_out_count = '0;
                        n_hex_left  = '0;
                        n_code_acc  = '0;
                        n_high_half = '0;
                        n_cont_left = '0;
                        n_min_class = '0;
                    end else begin
                        st = ST_BAD;
                    end
                end
                S_STR: begin
                    if (i_in_byte == 8'h22) begin
                        st = ST_DONE;
                    end else if (i_in_byte == 8'h5c) begin
                        n_phase = S_ESC;
                    end else if (i_in_byte < 8'h20) begin
                        st = ST_BAD;
                    end else if (i_in_byte < 8'h80) begin
                        want_cp = 1'b1;
                        cp_val  = CP_W'(i_in_byte);
                    end else if (i_in_byte inside {[8'hc2:8'hdf]}) begin
                        n_cont_left = 2'd1;
                        n_min_class = 2'd1;
                        n_code_acc  = CP_W'(i_in_byte[4:0]);
                        n_phase     = S_UTF8;
                    end else if (i_in_byte inside {[8'he0:8'hef]}) begin
                        n_cont_left = 2'd2;
                        n_min_class = 2'd2;
                        n_code_acc  = CP_W'(i_in_byte[3:0]);
                        n_phase     = S_UTF8;
                    end else if (i_in_byte inside {[8'hf0:8'hf4]}) begin
                        n_cont_left = 2'd3;
                        n_min_class = 2'd3;
                        n_code_acc  = CP_W'(i_in_byte[2:0]);
                        n_phase     = S_UTF8;
                    end else begin
                        st = ST_BAD;
                    end
                end
                S_ESC: begin
                    n_phase = S_STR;
                    want_cp = 1'b1;
                    case (i_in_byte)
                        8'h22, 8'h5c, 8'h2f: cp_val = CP_W'(i_in_byte);
                        8'h62: cp_val = 21'h08;
                        8'h66: cp_val = 21'h0c;
                        8'h6e: cp_val = 21'h0a;
                        8'h72: cp_val = 21'h0d;
                        8'h74: cp_val = 21'h09;
                        8'h75: begin
                            want_cp    = 1'b0;
                            n_phase    = S_HEX;
                            n_hex_left = 3'd4;
                            n_code_acc = '0;
                        end
                        default: begin
                            want_cp = 1'b0;
                            st      = ST_BAD;
                        end
                    endcase
                end
                S_HEX, S_PAIR_HEX: begin
                    if (hex_d[4] || r_hex_left == 3'd0) begin
                        st = ST_BAD;
                    end else begin
                        n_code_acc = CP_W'(hex_acc);
                        n_hex_left = r_hex_left - 3'd1;
                        if (r_hex_left != 3'd1) begin
                            st = ST_RUN;
                        end else if (r_phase == S_HEX) begin
                            if (hex_acc inside {[16'hd800:16'hdbff]}) begin
                                n_high_half = hex_acc[9:0];
                                n_phase     = S_PAIR_BS;
                            end else begin
                                n_phase = S_STR;
                                want_cp = 1'b1;
                                cp_val  = CP_W'(hex_acc);
                            end
                        end else if (!(hex_acc inside {[16'hdc00:16'hdfff]})) begin
                            st = ST_BAD;
                        end else begin
                            n_phase = S_STR;
                            want_cp = 1'b1;
                            cp_val  = 21'h10000 + CP_W'({r_high_half, hex_acc[9:0]});
                        end
                    end
                end
                S_PAIR_BS: begin
                    if (i_in_byte != 8'h5c) st = ST_BAD;
                    else n_phase = S_PAIR_U;
                end
                S_PAIR_U: begin
                    if (i_in_byte != 8'h75) begin
                        st = ST_BAD;
                    end else begin
                        n_phase    = S_PAIR_HEX;
                        n_hex_left = 3'd4;
                        n_code_acc = '0;
                    end
                end
                S_UTF8: begin
                    if (i_in_byte[7:6] != 2'b10 || r_cont_left == 2'd0) begin
                        st = ST_BAD;
                    end else begin
                        n_code_acc  = utf_acc;
                        n_cont_left = r_cont_left - 2'd1;
                        if (r_cont_left != 2'd1) begin
                            st = ST_RUN;
                        end else if (utf_acc < min_val || utf_acc > 21'h10ffff ||
                                     (utf_acc >= 21'hd800 && utf_acc <= 21'hdfff)) begin
                            st = ST_BAD;
                        end else begin
                            n_phase = S_STR;
                            want_cp = 1'b1;
                            cp_val  = utf_acc;
                        end
                    end
                end
                default: st = ST_BAD;
            endcase
        end

        // Append a code point: reject zero, surrogates and values above 0x10FFFF, then check capacity.
        len     = cp_len(cp_val);
        cap_sat = (CMPW'(r_capacity) > CAP_MAX) ? CAP_MAX : CMPW'(r_capacity);
        sum     = CMPW'(r_out_count) + CMPW'(len);
        if (want_cp) begin
            if (cp_val == '0 || cp_val > 21'h10ffff ||
                (cp_val >= 21'hd800 && cp_val <= 21'hdfff)) begin
                st      = ST_OVF;
                want_cp = 1'b0;
            end else if (r_limit_en && sum > cap_sat) begin
                st      = ST_OVF;
                want_cp = 1'b0;
            end else begin
                n_out_count = (sum > CNT_LIM) ? CW'(CNT_LIM) : CW'(sum);
            end
        end
        if (st != ST_RUN) n_phase = S_IDLE;

        o_evt.is_cp = want_cp;
        o_evt.st    = st;
        o_evt.cp    = cp_val;
        o_evt.len   = len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= S_IDLE;
            r_hex_left  <= '0;
            r_code_acc  <= '0;
            r_high_half <= '0;
            r_cont_left <= '0;
            r_min_class <= '0;
            r_out_count <= '0;
            r_capacity  <= CFG_DATA_W'(63);
            r_limit_en  <= 1'b1;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_OUT_CAPACITY: r_capacity <= i_cfg.data;
                    CFG_LIMIT_ENABLE: r_limit_en <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_phase     <= n_phase;
                r_hex_left  <= n_hex_left;
                r_code_acc  <= n_code_acc;
                r_high_half <= n_high_half;
                r_cont_left <= n_cont_left;
                r_min_class <= n_min_class;
                r_out_count <= n_out_count;
            end
        end
    end

endmodule

FILE: hdl/jsu_fifo.sv
`timescale 1ns / 1ps
module jsu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_evt i_evt,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output jsu_pkg::t_evt o_evt
);
    import jsu_pkg::*;

    t_evt              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_evt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/jsu_back.sv
`timescale 1ns / 1ps
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_evt i_evt,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic [1:0]    o_status,
    output logic          o_last
);
    import jsu_pkg::*;

    logic       r_busy;
    logic       r_is_cp;
    logic [1:0] r_st;
    logic [1:0] r_idx;
    logic [1:0] r_last_idx;
    logic [7:0] r_emit [4];

    logic        is_last;
    logic        take;
    logic [31:0] enc;

    assign is_last = !r_is_cp || (r_idx == r_last_idx);
    assign take    = r_busy && i_out_ready;
    assign o_pop   = !i_empty && (!r_busy || (take && is_last));
    assign enc     = utf8_encode(i_evt.cp);

    assign o_out_valid  = r_busy;
    assign o_out_byte   = r_is_cp ? r_emit[r_idx] : 8'd0;
    assign o_byte_valid = r_is_cp;
    assign o_status     = r_is_cp ? ST_RUN : r_st;
    assign o_last       = is_last;

    // The staged bytes have no reset; they are always loaded before use.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_emit[0] <= enc[7:0];
            r_emit[1] <= enc[15:8];
            r_emit[2] <= enc[23:16];
            r_emit[3] <= enc[31:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_is_cp    <= 1'b0;
            r_st       <= ST_RUN;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else if (o_pop) begin
            r_busy     <= 1'b1;
            r_is_cp    <= i_evt.is_cp;
            r_st       <= i_evt.st;
            r_idx      <= '0;
            r_last_idx <= 2'(i_evt.len - 3'd1);
        end else if (take) begin
            if (is_last) r_busy <= 1'b0;
            else r_idx <= r_idx + 2'd1;
        end
    end

endmodule

FILE: hdl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_req_type, i_in_byte
// result    o_out_valid / i_out_ready  o_out_byte, o_byte_valid, o_status, o_last
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// The front end decodes one byte per cycle and writes one entry per byte into a
// four-entry queue; it stalls only when that queue is full.
// The back end sends one result per cycle while i_out_ready is high, 1 to 4 per
// byte; each entry goes through the queue into the back end's result register.
// Synchronous active-low reset clears all control state; capacity resets to 63
// with the limit enabled. Both ready outputs are low during reset, and config
// writes are otherwise always accepted.
module json_string_unescape_utf8 #(
    parameter int CAPACITY_MAX = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [7:0]                       i_in_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_byte_valid,
    output logic [1:0]                       o_status,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jsu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jsu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import jsu_pkg::*;

    t_evt    front_evt;
    t_evt    queue_evt;
    t_cfg_wr cfg;
    logic    accept;
    logic    full;
    logic    empty;
    logic    pop;

    assign o_cfg_ready = i_rst_n;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;
    assign o_in_ready  = i_rst_n && !full;
    assign accept      = i_in_valid && o_in_ready;

    jsu_front #(.CAPACITY_MAX(CAPACITY_MAX)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_in_byte  (i_in_byte),
        .i_cfg      (cfg),
        .o_evt      (front_evt)
    );

    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_evt   (front_evt),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_evt   (queue_evt)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_evt        (queue_evt),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

FILE: hdl/jsu_checker.sv
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_assert.svh"
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic [1:0] o_status,
    input logic       o_last
);
    import jsu_pkg::*;

    // Reset empties the result register.
    `JSU_ASSERT_NEXT(a_rst_idle, i_clk, 1'b0, !i_rst_n, !o_out_valid)
    // A status result stands alone; a data result carries the running status.
    `JSU_ASSERT_IMPLY(a_status_last, i_clk, !i_rst_n, o_out_valid && !o_byte_valid, o_last)
    `JSU_ASSERT_IMPLY(a_data_run, i_clk, !i_rst_n,
        o_out_valid && o_byte_valid, o_status == ST_RUN && o_out_byte != 8'd0)
    `JSU_ASSERT_NEXT(a_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_byte) && $stable(o_status) && $stable(o_last))
endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_status     (o_status),
    .o_last       (o_last)
);

FILE: tb/sv/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int CAP_LIMIT   = 4096;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_STR, SCAN_ESC, SCAN_HEX,
        SCAN_PAIR_BS, SCAN_PAIR_U, SCAN_PAIR_HEX, SCAN_UTF8
    } t_scan_phase;

    typedef struct packed {
        logic       req_end;
        logic [7:0] raw;
    } t_body_req;

    typedef struct packed {
        logic [7:0] data;
        logic       is_data;
        logic [1:0] st;
        logic       lst;
    } t_decoded_item;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_req_type  = 1'b0;
    logic [7:0]            i_in_byte   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [7:0]            o_out_byte;
    logic                  o_byte_valid;
    logic [1:0]            o_status;
    logic                  o_last;
    logic                  o_cfg_ready;

    json_string_unescape_utf8 #(
        .CAPACITY_MAX(CAP_LIMIT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_status     (o_status),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    t_body_req     pending_reqs[$];
    t_decoded_item expected_results[$];
    int unsigned   queued_total   = 0;
    int unsigned   accepted_total = 0;
    int unsigned   result_errors  = 0;
    int unsigned   tx_idle_pct    = 0;
    int unsigned   rx_idle_pct    = 0;
    int unsigned   hold_req       = 0;
    int unsigned   hold_seen      = 0;
    int unsigned   hold_left      = 0;
    int unsigned   quiet_cycles   = 0;

    // Decoder state as the block should hold it.
    t_scan_phase   scan_phase = SCAN_IDLE;
    logic [2:0]    hex_left   = '0;
    logic [20:0]   code_acc   = '0;
    logic [9:0]    high_half  = '0;
    logic [1:0]    cont_left  = '0;
    logic [1:0]    min_class  = '0;
    int unsigned   byte_count = 0;
    logic [12:0]   cap_reg    = 13'd63;
    logic          limit_en   = 1'b1;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int encode_utf8(input logic [20:0] cp, output logic [31:0] seq);
        seq = '0;
        if (cp <= 21'h7f) begin
            seq[7:0] = cp[7:0];
            return 1;
        end
        if (cp <= 21'h7ff) begin
            seq[7:0]  = 8'hc0 | 8'(cp >> 6);
            seq[15:8] = 8'h80 | 8'(cp & 21'h3f);
            return 2;
        end
        if (cp <= 21'hffff) begin
            seq[7:0]   = 8'he0 | 8'(cp >> 12);
            seq[15:8]  = 8'h80 | 8'((cp >> 6) & 21'h3f);
            seq[23:16] = 8'h80 | 8'(cp & 21'h3f);
            return 3;
        end
        seq[7:0]   = 8'hf0 | 8'(cp >> 18);
        seq[15:8]  = 8'h80 | 8'((cp >> 12) & 21'h3f);
        seq[23:16] = 8'h80 | 8'((cp >> 6) & 21'h3f);
        seq[31:24] = 8'h80 | 8'(cp & 21'h3f);
        return 4;
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
        return 5'd16;
    endfunction

    function automatic void post_status(input logic [1:0] st);
        if (st != ST_RUN) scan_phase = SCAN_IDLE;
        expected_results.push_back('{8'h00, 1'b0, st, 1'b1});
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        logic [31:0] seq;
        int          n;
        int unsigned cap;
        if (cp == 0 || (cp >= 21'hd800 && cp <= 21'hdfff) || cp > 21'h10ffff) begin
            post_status(ST_OVF);
            return;
        end
        n = encode_utf8(cp, seq);
        cap = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
        // A code point that does not fit is dropped whole.
        if (limit_en && byte_count + n > cap) begin
            post_status(ST_OVF);
            return;
        end
        byte_count = (byte_count + n > CAP_LIMIT + 4) ? CAP_LIMIT + 4 : byte_count + n;
        for (int i = 0; i < n; i++)
            expected_results.push_back('{seq[8*i +: 8], 1'b1, ST_RUN, i == n - 1});
    endfunction

    function automatic void open_multibyte(input logic [1:0] count, input logic [20:0] bits);
        cont_left  = count;
        min_class  = count;
        code_acc   = bits;
        scan_phase = SCAN_UTF8;
        post_status(ST_RUN);
    endfunction

    function automatic void decode_request(input logic req_end, input logic [7:0] b);
        logic [4:0]  d;
        logic [20:0] minv;
        if (req_end) begin
            post_status(ST_BAD);
            return;
        end
        case (scan_phase)
            SCAN_IDLE: begin
                if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
                    post_status(ST_RUN);
                end else if (b == CH_QUOTE) begin
                    scan_phase = SCAN_STR;
                    byte_count = 0;
                    hex_left   = '0;
                    code_acc   = '0;
                    high_half  = '0;
                    cont_left  = '0;
                    min_class  = '0;
                    post_status(ST_RUN);
                end else begin
                    post_status(ST_BAD);
                end
            end
            SCAN_STR: begin
                if (b == CH_QUOTE) post_status(ST_DONE);
                else if (b == CH_BSLASH) begin
                    scan_phase = SCAN_ESC;
                    post_status(ST_RUN);
                end else if (b < 8'h20) post_status(ST_BAD);
                else if (b < 8'h80) emit_code_point(21'(b));
                else if (b >= 8'hc2 && b <= 8'hdf) open_multibyte(2'd1, 21'(b & 8'h1f));
                else if (b >= 8'he0 && b <= 8'hef) open_multibyte(2'd2, 21'(b & 8'h0f));
                else if (b >= 8'hf0 && b <= 8'hf4) open_multibyte(2'd3, 21'(b & 8'h07));
                else post_status(ST_BAD);
            end
            SCAN_ESC: begin
                scan_phase = SCAN_STR;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: emit_code_point(21'(b));
                    CH_B: emit_code_point(21'h08);
                    CH_F: emit_code_point(21'h0c);
                    CH_N: emit_code_point(21'h0a);
                    CH_R: emit_code_point(21'h0d);
                    CH_T: emit_code_point(21'h09);
                    CH_U: begin
                        scan_phase = SCAN_HEX;
                        hex_left   = 3'd4;
                        code_acc   = '0;
                        post_status(ST_RUN);
                    end
                    default: post_status(ST_BAD);
                endcase
            end
            SCAN_HEX, SCAN_PAIR_HEX: begin
                d = hex_digit(b);
                if (d > 5'd15 || hex_left == 0) begin
                    post_status(ST_BAD);
                end else begin
                    code_acc = {5'b0, code_acc[11:0], d[3:0]};
                    hex_left = hex_left - 3'd1;
                    if (hex_left != 0) begin
                        post_status(ST_RUN);
                    end else if (scan_phase == SCAN_HEX) begin
                        if (code_acc >= 21'hd800 && code_acc <= 21'hdbff) begin
                            high_half  = code_acc[9:0];
                            scan_phase = SCAN_PAIR_BS;
                            post_status(ST_RUN);
                        end else begin
                            scan_phase = SCAN_STR;
                            emit_code_point(code_acc);
                        end
                    end else if (code_acc < 21'hdc00 || code_acc > 21'hdfff) begin
                        post_status(ST_BAD);
                    end else begin
                        scan_phase = SCAN_STR;
                        emit_code_point(21'h10000 + {high_half, code_acc[9:0]});
                    end
                end
            end
            SCAN_PAIR_BS: begin
                if (b != CH_BSLASH) post_status(ST_BAD);
                else begin
                    scan_phase = SCAN_PAIR_U;
                    post_status(ST_RUN);
                end
            end
            SCAN_PAIR_U: begin
                if (b != CH_U) post_status(ST_BAD);
                else begin
                    scan_phase = SCAN_PAIR_HEX;
                    hex_left   = 3'd4;
                    code_acc   = '0;
                    post_status(ST_RUN);
                end
            end
            SCAN_UTF8: begin
                if (b[7:6] != 2'b10 || cont_left == 0) begin
                    post_status(ST_BAD);
                end else begin
                    code_acc  = {code_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left != 0) begin
                        post_status(ST_RUN);
                    end else begin
                        minv = (min_class == 2'd1) ? 21'h80 :
                               (min_class == 2'd2) ? 21'h800 : 21'h10000;
                        if (code_acc < minv || code_acc > 21'h10ffff ||
                            (code_acc >= 21'hd800 && code_acc <= 21'hdfff)) begin
                            post_status(ST_BAD);
                        end else begin
                            scan_phase = SCAN_STR;
                            emit_code_point(code_acc);
                        end
                    end
                end
            end
            default: post_status(ST_BAD);
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        pending_reqs.push_back('{1'b0, b});
        queued_total++;
    endtask

    task automatic queue_end();
        pending_reqs.push_back('{1'b1, 8'($urandom)});
        queued_total++;
    endtask

    task automatic queue_noise();
        if ($urandom_range(0, 7) == 0) queue_end();
        else queue_byte(8'($urandom));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    task automatic queue_u_escape(input logic [15:0] v);
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        for (int k = 3; k >= 0; k--) queue_byte(hex_char(v[4*k +: 4]));
    endtask

    task automatic queue_raw_cp(input logic [20:0] cp);
        logic [31:0] seq;
        int          n;
        n = encode_utf8(cp, seq);
        for (int i = 0; i < n; i++) queue_byte(seq[8*i +: 8]);
    endtask

    // One well-formed piece of string content.
    task automatic queue_element();
        logic [7:0]  b;
        logic [15:0] v;
        logic [20:0] cp;
        case ($urandom_range(0, 7))
            0, 1: begin
                do b = 8'($urandom_range(8'h20, 8'h7f));
                while (b == CH_QUOTE || b == CH_BSLASH);
                queue_byte(b);
            end
            2: begin
                queue_byte(CH_BSLASH);
                case ($urandom_range(0, 7))
                    0: queue_byte(CH_QUOTE);
                    1: queue_byte(CH_BSLASH);
                    2: queue_byte(CH_SLASH);
                    3: queue_byte(CH_B);
                    4: queue_byte(CH_F);
                    5: queue_byte(CH_N);
                    6: queue_byte(CH_R);
                    default: queue_byte(CH_T);
                endcase
            end
            3: begin
                case ($urandom_range(0, 2))
                    0: v = 16'($urandom_range(16'h0001, 16'h007f));
                    1: v = 16'($urandom_range(16'h0080, 16'h07ff));
                    default: begin
                        do v = 16'($urandom_range(16'h0800, 16'hffff));
                        while (v >= 16'hd800 && v <= 16'hdfff);
                    end
                endcase
                queue_u_escape(v);
            end
            4: begin
                queue_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
                queue_u_escape(16'($urandom_range(16'hdc00, 16'hdfff)));
            end
            5: queue_raw_cp(21'($urandom_range(21'h80, 21'h7ff)));
            6: begin
                do cp = 21'($urandom_range(21'h800, 21'hffff));
                while (cp >= 21'hd800 && cp <= 21'hdfff);
                queue_raw_cp(cp);
            end
            default: queue_raw_cp(21'($urandom_range(21'h10000, 21'h10ffff)));
        endcase
    endtask

    // Mostly complete strings, some broken at a random point, some raw noise.
    task automatic queue_random(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        logic [7:0]  b;
        logic [15:0] v;
        start = queued_total;
        while (queued_total - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick >= 88) begin
                repeat ($urandom_range(1, 4)) queue_noise();
            end else begin
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 3))
                        0: queue_byte(CH_SPACE);
                        1: queue_byte(CH_TAB);
                        2: queue_byte(CH_CR);
                        default: queue_byte(CH_LF);
                    endcase
                end
                queue_byte(CH_QUOTE);
                repeat ($urandom_range(0, pick < 65 ? 10 : 3)) queue_element();
                if (pick < 65) begin
                    queue_byte(CH_QUOTE);
                end else begin
                    case ($urandom_range(0, 16))
                        0: queue_byte(8'($urandom_range(0, 31)));
                        1: begin
                            if ($urandom_range(0, 1)) queue_byte(8'($urandom_range(8'h80, 8'hc1)));
                            else queue_byte(8'($urandom_range(8'hf5, 8'hff)));
                        end
                        2: begin
                            queue_byte(8'($urandom_range(8'hc2, 8'hdf)));
                            b = 8'($urandom);
                            if (b[7:6] == 2'b10) b[6] = 1'b1;
                            queue_byte(b);
                        end
                        3: begin
                            // Sequence cut short by the closing quote.
                            queue_byte(8'($urandom_range(8'he0, 8'hef)));
                            queue_byte(8'($urandom_range(8'h80, 8'hbf)));
                            queue_byte(CH_QUOTE);
                        end
                        4: begin
                            queue_byte(8'he0);
                            queue_byte(8'($urandom_range(8'h80, 8'h9f)));
                            queue_byte(8'($urandom_range(8'h80, 8'hbf)));
                        end
                        5: begin
                            queue_byte(8'hf0);
                            queue_byte(8'($urandom_range(8'h80, 8'h8f)));
                            queue_byte(8'($urandom_range(8'h80, 8'hbf)));
                            queue_byte(8'($urandom_range(8'h80, 8'hbf)));
                        end
                        6: begin
                            queue_byte(8'hed);
                            queue_byte(8'($urandom_range(8'ha0, 8'hbf)));
                            queue_byte(8'($urandom_range(8'h80, 8'hbf)));
                        end
                        7: begin
                            queue_byte(8'hf4);
                            queue_byte(8'($urandom_range(8'h90, 8'hbf)));
                            queue_byte(8'($urandom_range(8'h80, 8'hbf)));
                            queue_byte(8'($urandom_range(8'h80, 8'hbf)));
                        end
                        8: begin
                            b = 8'($urandom);
                            if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH ||
                                b == CH_B || b == CH_F || b == CH_N || b == CH_R ||
                                b == CH_T || b == CH_U) b = 8'h78;
                            queue_byte(CH_BSLASH);
                            queue_byte(b);
                        end
                        9: begin
                            queue_byte(CH_BSLASH);
                            queue_byte(CH_U);
                            repeat ($urandom_range(0, 3)) queue_byte(hex_char(4'($urandom)));
                            b = 8'($urandom);
                            if (hex_digit(b) < 5'd16) b = 8'h67;
                            queue_byte(b);
                        end
                        10: queue_u_escape(16'h0000);
                        11: queue_u_escape(16'($urandom_range(16'hdc00, 16'hdfff)));
                        12: begin
                            queue_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
                            b = 8'($urandom);
                            if (b == CH_BSLASH) b = 8'h41;
                            queue_byte(b);
                        end
                        13: begin
                            queue_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
                            queue_byte(CH_BSLASH);
                            b = 8'($urandom);
                            if (b == CH_U) b = 8'h55;
                            queue_byte(b);
                        end
                        14: begin
                            queue_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
                            v = 16'($urandom);
                            if (v >= 16'hdc00 && v <= 16'hdfff) v = v ^ 16'h2000;
                            queue_u_escape(v);
                        end
                        15: queue_end();
                        default: begin
                            // Closed string followed by junk while idle.
                            queue_byte(CH_QUOTE);
                            b = 8'($urandom);
                            if (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB ||
                                b == CH_CR || b == CH_LF) b = 8'h7b;
                            queue_byte(b);
                        end
                    endcase
                    repeat ($urandom_range(0, 2)) queue_noise();
                end
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_OUT_CAPACITY) cap_reg = val;
        else limit_en = val[0];
    endtask

    task automatic drain_results();
        do @(posedge i_clk);
        while (accepted_total != queued_total || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Request driver: holds each byte until it is taken.
    always @(posedge i_clk) begin : drive_proc
        t_body_req nxt;
        logic      fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                decode_request(i_req_type, i_in_byte);
                accepted_total++;
            end
            if (!i_in_valid || fire) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= nxt.req_end;
                    i_in_byte  <= nxt.raw;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_proc
        t_decoded_item want;
        logic          rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    result_errors++;
                    if (result_errors <= 10)
                        $display("unexpected result: byte=%h valid=%b status=%0d last=%b",
                                 o_out_byte, o_byte_valid, o_status, o_last);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_byte != want.data || o_byte_valid != want.is_data ||
                        o_status != want.st || o_last != want.lst) begin
                        result_errors++;
                        if (result_errors <= 10)
                            $display({"mismatch: expected byte=%h valid=%b status=%0d last=%b,",
                                      " got byte=%h valid=%b status=%0d last=%b"},
                                     want.data, want.is_data, want.st, want.lst,
                                     o_out_byte, o_byte_valid, o_status, o_last);
                    end
                end
            end
            // A long hold-off lets the block back up into its input.
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = $urandom_range(0, 99) >= rx_idle_pct;
            end
            i_out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : main_seq
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, no idling: field extremes and the main paths.
        queue_byte(CH_SPACE);
        queue_byte(CH_TAB);
        queue_byte(CH_QUOTE);
        queue_byte(8'h41);
        queue_byte(8'h7f);
        queue_byte(CH_BSLASH);
        queue_byte(CH_N);
        queue_u_escape(16'h00e9);
        queue_raw_cp(21'h10ffff);
        queue_raw_cp(21'h80);
        queue_byte(CH_QUOTE);
        queue_byte(8'h00);
        queue_byte(CH_QUOTE);
        queue_byte(8'hff);
        pending_reqs.push_back('{1'b1, 8'hff});
        queued_total++;
        queue_byte(CH_CR);
        queue_random(30);
        drain_results();

        write_register(CFG_OUT_CAPACITY, 13'd4096);
        write_register(CFG_LIMIT_ENABLE, {12'($urandom), 1'b1});
        tx_idle_pct <= 53;
        rx_idle_pct <= 0;
        queue_random(75);
        drain_results();

        // Capacity beyond the maximum, limit off.
        write_register(CFG_OUT_CAPACITY, 13'h1fff);
        write_register(CFG_LIMIT_ENABLE, {12'($urandom), 1'b0});
        tx_idle_pct <= 0;
        rx_idle_pct <= 53;
        queue_random(75);
        drain_results();

        // Zero capacity: every code point overflows.
        write_register(CFG_OUT_CAPACITY, 13'd0);
        write_register(CFG_LIMIT_ENABLE, {12'($urandom), 1'b1});
        tx_idle_pct <= 10;
        rx_idle_pct <= 10;
        queue_random(40);
        drain_results();

        write_register(CFG_OUT_CAPACITY, 13'($urandom_range(4, 24)));
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        hold_req <= hold_req + 1;
        queue_random(100);
        drain_results();

        // Limit enabled in the middle of a string already past capacity.
        write_register(CFG_OUT_CAPACITY, 13'd5);
        write_register(CFG_LIMIT_ENABLE, {12'($urandom), 1'b0});
        queue_byte(CH_QUOTE);
        repeat (12) queue_byte(8'h78);
        drain_results();
        write_register(CFG_LIMIT_ENABLE, {12'($urandom), 1'b1});
        queue_byte(8'h79);
        drain_results();

        write_register(CFG_OUT_CAPACITY, 13'($urandom_range(30, 200)));
        tx_idle_pct <= 10;
        rx_idle_pct <= 10;
        queue_random(75);
        drain_results();

        repeat (16) @(posedge i_clk);
        if (expected_results.size() != 0) result_errors++;
        if (result_errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
